/* src/rms_pkg.sv */
// Shared types and constants for the reliable message sequencer.
package rms_pkg;

    localparam logic [1:0] KIND_SEND = 2'd0;
    localparam logic [1:0] KIND_RECV = 2'd1;
    localparam logic [1:0] KIND_ACK  = 2'd2;
    localparam logic [1:0] KIND_TICK = 2'd3;

    localparam logic [1:0] ACT_DATA    = 2'd0;
    localparam logic [1:0] ACT_ACK     = 2'd1;
    localparam logic [1:0] ACT_DELIVER = 2'd2;
    localparam logic [1:0] ACT_FULL    = 2'd3;

    localparam logic [31:0] RESEND_DELAY_RST = 32'd300;
    localparam int          MAX_RESULTS      = 32;
    localparam int          RES_CNT_W        = 6;

    typedef struct packed {
        logic [31:0] id;
        logic [25:0] rl;
        logic [31:0] stamp;
    } t_tx_entry;

    typedef struct packed {
        logic [31:0] id;
        logic [25:0] rl;
    } t_rx_entry;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] id;
        logic [15:0] pref;
        logic [9:0]  len;
    } t_result;

    typedef struct packed {
        logic push;
        logic flush;
    } t_res_ctl;

endpackage

/* src/rms_mem.sv */
// Single-port-write, single-port-read synchronous table with registered read data.
module rms_mem #(
    parameter int W     = 58,
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, registered read data
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* src/rms_result.sv */
// Result holding stage: delays each result by one so the final one can be marked last.
module rms_result (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rms_pkg::t_res_ctl i_ctl,
    input  rms_pkg::t_result  i_res,
    output logic              o_valid,
    output logic [1:0]        o_action,
    output logic [31:0]       o_out_id,
    output logic [15:0]       o_out_ref,
    output logic [9:0]        o_out_len,
    output logic              o_last
);
    import rms_pkg::*;

    logic    r_pend;
    t_result r_hold;
    logic    r_valid;
    logic    r_last;
    t_result r_out;

    // pending flag and output strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= r_pend && (i_ctl.push || i_ctl.flush);
            if (i_ctl.push) begin
                r_pend <= 1'b1;
            end else if (i_ctl.flush) begin
                r_pend <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_ctl.push || i_ctl.flush) begin
            r_out  <= r_hold;
            r_last <= !i_ctl.push;
        end
        if (i_ctl.push) begin
            r_hold <= i_res;
        end
    end

    assign o_valid   = r_valid;
    assign o_action  = r_out.action;
    assign o_out_id  = r_out.id;
    assign o_out_ref = r_out.pref;
    assign o_out_len = r_out.len;
    assign o_last    = r_last;

endmodule

/* src/reliable_message_sequencer_top.sv */
// Reliable message sequencer: sequencer over transmit and receive tables.
// One event at a time; busy is high from the accepting edge until the event is finished.
// Send writes the transmit table; receive and ack search the receive and transmit tables;
// tick rescans the receive table after each delivery, then scans the transmit table, one read per step.
// A result is held until the next one is found or the event ends, then strobed once.
// Synchronous active-low reset empties both tables and sets resend_delay to 300.
module reliable_message_sequencer_top #(
    parameter int TX_DEPTH = 16,
    parameter int RX_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_kind,
    input  logic [31:0] i_now,
    input  logic [31:0] i_msg_id,
    input  logic [15:0] i_payload_ref,
    input  logic [9:0]  i_payload_len,
    output logic        o_valid,
    output logic [1:0]  o_action,
    output logic [31:0] o_out_id,
    output logic [15:0] o_out_ref,
    output logic [9:0]  o_out_len,
    output logic        o_last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import rms_pkg::*;

    localparam int MAXD = (TX_DEPTH > RX_DEPTH) ? TX_DEPTH : RX_DEPTH;
    localparam int CW   = $clog2(MAXD + 1);
    localparam int TAW  = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
    localparam int RAW  = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
    localparam int TXW  = $bits(t_tx_entry);
    localparam int RXW  = $bits(t_rx_entry);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DISP  = 4'd1;
    localparam logic [3:0] S_RXCHK = 4'd2;
    localparam logic [3:0] S_RXCMP = 4'd3;
    localparam logic [3:0] S_TXCHK = 4'd4;
    localparam logic [3:0] S_TXCMP = 4'd5;
    localparam logic [3:0] S_TXMOV = 4'd6;
    localparam logic [3:0] S_DLCHK = 4'd7;
    localparam logic [3:0] S_DLCMP = 4'd8;
    localparam logic [3:0] S_DLMOV = 4'd9;
    localparam logic [3:0] S_RTCHK = 4'd10;
    localparam logic [3:0] S_RTCMP = 4'd11;
    localparam logic [3:0] S_DONE  = 4'd12;

    logic [3:0]           r_state, n_state;
    logic [CW-1:0]        r_idx, n_idx;
    logic [CW-1:0]        r_tx_count, n_tx_count;
    logic [CW-1:0]        r_rx_count, n_rx_count;
    logic [31:0]          r_next_send, n_next_send;
    logic [31:0]          r_next_dlv, n_next_dlv;
    logic [RES_CNT_W-1:0] r_nres, n_nres;
    logic [31:0]          r_delay;

    // latched event
    logic [1:0]  r_kind;
    logic [31:0] r_now;
    logic [31:0] r_id;
    logic [25:0] r_rl;

    logic            tx_we, rx_we;
    logic [TAW-1:0]  tx_waddr, tx_raddr;
    logic [RAW-1:0]  rx_waddr, rx_raddr;
    t_tx_entry       tx_wdata, tx_rdata;
    t_rx_entry       rx_wdata, rx_rdata;
    logic [TXW-1:0]  tx_rbits;
    logic [RXW-1:0]  rx_rbits;
    logic [CW-1:0]   tx_lastslot, rx_lastslot;
    logic [31:0]     age;
    logic            res_room;

    t_res_ctl res_ctl;
    t_result  res;

    assign tx_rdata    = t_tx_entry'(tx_rbits);
    assign rx_rdata    = t_rx_entry'(rx_rbits);
    assign tx_lastslot = r_tx_count - 1'b1;
    assign rx_lastslot = r_rx_count - 1'b1;
    assign age         = r_now - tx_rdata.stamp;
    assign res_room    = r_nres < RES_CNT_W'(MAX_RESULTS);
    assign busy        = (r_state != S_IDLE);

    // configuration port
    assign pready = 1'b1;
    assign prdata = (paddr == 3'd0) ? r_delay : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay <= RESEND_DELAY_RST;
        end else if (psel && penable && pwrite && (paddr == 3'd0)) begin
            r_delay <= pwdata;
        end
    end

    // event capture
    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_kind <= i_kind;
            r_now  <= i_now;
            r_id   <= i_msg_id;
            r_rl   <= {i_payload_ref, i_payload_len};
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_tx_count  <= '0;
            r_rx_count  <= '0;
            r_next_send <= '0;
            r_next_dlv  <= '0;
            r_nres      <= '0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_tx_count  <= n_tx_count;
            r_rx_count  <= n_rx_count;
            r_next_send <= n_next_send;
            r_next_dlv  <= n_next_dlv;
            r_nres      <= n_nres;
        end
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_tx_count  = r_tx_count;
        n_rx_count  = r_rx_count;
        n_next_send = r_next_send;
        n_next_dlv  = r_next_dlv;
        n_nres      = r_nres;
        tx_we       = 1'b0;
        rx_we       = 1'b0;
        tx_waddr    = r_idx[TAW-1:0];
        rx_waddr    = r_idx[RAW-1:0];
        tx_raddr    = r_idx[TAW-1:0];
        rx_raddr    = r_idx[RAW-1:0];
        tx_wdata    = tx_rdata;
        rx_wdata    = rx_rdata;
        res_ctl     = '0;
        res         = '0;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                n_idx  = '0;
                n_nres = '0;
                unique case (r_kind)
                    KIND_SEND: begin
                        res_ctl.push = 1'b1;
                        res.id       = r_next_send;
                        res.pref     = r_rl[25:10];
                        res.len      = r_rl[9:0];
                        if (r_tx_count >= CW'(TX_DEPTH)) begin
                            res.action = ACT_FULL;
                        end else begin
                            res.action     = ACT_DATA;
                            tx_we          = 1'b1;
                            tx_waddr       = r_tx_count[TAW-1:0];
                            tx_wdata       = '{id: r_next_send, rl: r_rl, stamp: r_now};
                            n_tx_count     = r_tx_count + 1'b1;
                            n_next_send    = r_next_send + 32'd1;
                        end
                        n_state = S_DONE;
                    end
                    KIND_RECV: begin
                        res_ctl.push = 1'b1;
                        res.action   = ACT_ACK;
                        res.id       = r_id;
                        n_state      = (r_id < r_next_dlv) ? S_DONE : S_RXCHK;
                    end
                    KIND_ACK: begin
                        n_state = S_TXCHK;
                    end
                    default: begin
                        n_state = S_DLCHK;
                    end
                endcase
            end
            // duplicate search in the receive table
            S_RXCHK: begin
                if (r_idx < r_rx_count) begin
                    n_state = S_RXCMP;
                end else begin
                    if (r_rx_count >= CW'(RX_DEPTH)) begin
                        res_ctl.push = 1'b1;
                        res.action   = ACT_FULL;
                        res.id       = r_id;
                        res.pref     = r_rl[25:10];
                        res.len      = r_rl[9:0];
                    end else begin
                        rx_we      = 1'b1;
                        rx_waddr   = r_rx_count[RAW-1:0];
                        rx_wdata   = '{id: r_id, rl: r_rl};
                        n_rx_count = r_rx_count + 1'b1;
                    end
                    n_state = S_DONE;
                end
            end
            S_RXCMP: begin
                if (rx_rdata.id == r_id) begin
                    n_state = S_DONE;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_RXCHK;
                end
            end
            // ack: find the entry, then move the last slot into it
            S_TXCHK: begin
                n_state = (r_idx < r_tx_count) ? S_TXCMP : S_DONE;
            end
            S_TXCMP: begin
                if (tx_rdata.id == r_id) begin
                    tx_raddr = tx_lastslot[TAW-1:0];
                    n_state  = S_TXMOV;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_TXCHK;
                end
            end
            S_TXMOV: begin
                tx_we      = 1'b1;
                n_tx_count = tx_lastslot;
                n_state    = S_DONE;
            end
            // tick: in-order delivery
            S_DLCHK: begin
                if (!res_room || !(r_idx < r_rx_count)) begin
                    n_idx   = '0;
                    n_state = S_RTCHK;
                end else begin
                    n_state = S_DLCMP;
                end
            end
            S_DLCMP: begin
                if (rx_rdata.id == r_next_dlv) begin
                    res_ctl.push = 1'b1;
                    res.action   = ACT_DELIVER;
                    res.id       = rx_rdata.id;
                    res.pref     = rx_rdata.rl[25:10];
                    res.len      = rx_rdata.rl[9:0];
                    n_nres       = r_nres + 1'b1;
                    rx_raddr     = rx_lastslot[RAW-1:0];
                    n_state      = S_DLMOV;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_DLCHK;
                end
            end
            S_DLMOV: begin
                rx_we      = 1'b1;
                n_rx_count = rx_lastslot;
                n_next_dlv = r_next_dlv + 32'd1;
                n_idx      = '0;
                n_state    = S_DLCHK;
            end
            // tick: retransmit aged entries
            S_RTCHK: begin
                n_state = (res_room && (r_idx < r_tx_count)) ? S_RTCMP : S_DONE;
            end
            S_RTCMP: begin
                if (age >= r_delay) begin
                    res_ctl.push = 1'b1;
                    res.action   = ACT_DATA;
                    res.id       = tx_rdata.id;
                    res.pref     = tx_rdata.rl[25:10];
                    res.len      = tx_rdata.rl[9:0];
                    n_nres       = r_nres + 1'b1;
                    tx_we        = 1'b1;
                    tx_wdata     = '{id: tx_rdata.id, rl: tx_rdata.rl, stamp: r_now};
                end
                n_idx   = r_idx + 1'b1;
                n_state = S_RTCHK;
            end
            S_DONE: begin
                res_ctl.flush = 1'b1;
                n_state       = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    rms_mem #(.W(TXW), .DEPTH(TX_DEPTH), .AW(TAW)) u_tx_mem (
        .i_clk   (i_clk),
        .i_we    (tx_we),
        .i_waddr (tx_waddr),
        .i_wdata (tx_wdata),
        .i_raddr (tx_raddr),
        .o_rdata (tx_rbits)
    );

    rms_mem #(.W(RXW), .DEPTH(RX_DEPTH), .AW(RAW)) u_rx_mem (
        .i_clk   (i_clk),
        .i_we    (rx_we),
        .i_waddr (rx_waddr),
        .i_wdata (rx_wdata),
        .i_raddr (rx_raddr),
        .o_rdata (rx_rbits)
    );

    rms_result u_result (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (res_ctl),
        .i_res     (res),
        .o_valid   (o_valid),
        .o_action  (o_action),
        .o_out_id  (o_out_id),
        .o_out_ref (o_out_ref),
        .o_out_len (o_out_len),
        .o_last    (o_last)
    );

endmodule
